[hdl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// Supply and temperature conversion package
// Shared widths, constants, register indexes, controller state and the
// command and status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package stc_pkg;

   localparam int ADC_SUM_W = 16;
   localparam int AVG_W     = 10;
   localparam int SUPPLY_W  = 16;
   localparam int TEMP_W    = 15;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;
   localparam int PROD_W    = 21;

   // Average is the sum of 64 samples divided by 64.
   localparam int AVG_SHIFT = 6;

   // 110 * 512, the reference voltage scaled for centivolts.
   localparam logic [SUPPLY_W-1:0] SUPPLY_NUMERATOR = 16'd56320;
   localparam logic [SUPPLY_W-1:0] SUPPLY_SATURATED = 16'hFFFF;
   localparam int                  DIV_STEPS        = SUPPLY_W;
   localparam int                  DIV_CNT_W        = $clog2(DIV_STEPS);

   localparam logic signed [PROD_W-1:0] KELVIN_BIAS = 21'sd69926;
   localparam int                       TEMP_SHIFT  = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_GAIN   = 1'b1;

   localparam logic CH_SUPPLY = 1'b0;
   localparam logic CH_TEMP   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_MUL,
      ST_TEMP,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic mul_step;
      logic temp_step;
      logic out_load;
      logic channel;
   } cmd_type;

   typedef struct packed {
      logic avg_zero;
   } status_type;

endpackage

[hdl/stc_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one accumulated converter sum per word.
// ----------------------------------------------------------------------------
interface stc_req_if
   import stc_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [ADC_SUM_W-1:0] adc_sum;

   modport source (output valid, output adc_sum, input ready);
   modport sink   (input valid, input adc_sum, output ready);
endinterface

[hdl/stc_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one supply or temperature reading per word.
// ----------------------------------------------------------------------------
interface stc_rsp_if
   import stc_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic                     channel;
   logic [SUPPLY_W-1:0]      supply_centivolts;
   logic signed [TEMP_W-1:0] temp_decidegrees;
   logic                     zero_reading;

   modport source (output valid, output channel, output supply_centivolts,
                   output temp_decidegrees, output zero_reading, input ready);
   modport sink   (input valid, input channel, input supply_centivolts,
                   input temp_decidegrees, input zero_reading, output ready);
endinterface

[hdl/stc_ctrl.sv]
// ----------------------------------------------------------------------------
// Supply and temperature conversion controller
// Sequences one word at a time through the divider or the temperature path.
// ----------------------------------------------------------------------------
module stc_ctrl
   import stc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type              state_ff, state_in;
   logic                   channel_ff, channel_in;
   logic [DIV_CNT_W-1:0]   div_count_ff, div_count_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   div_last;
   logic                   out_free;

   assign div_last = (div_count_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            if (channel_ff == CH_TEMP) state_in = ST_MUL;
            else if (status.avg_zero)  state_in = ST_WRITE;
            else                       state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = ST_WRITE;
         end
         ST_MUL:   state_in = ST_TEMP;
         ST_TEMP:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.mul_step  = (state_ff == ST_MUL);
      cmd.temp_step = (state_ff == ST_TEMP);
      cmd.out_load  = (state_ff == ST_WRITE) && out_free;
      cmd.channel   = channel_ff;
   end

   always_comb begin
      channel_in   = cmd.out_load ? !channel_ff : channel_ff;
      div_count_in = (state_ff == ST_DIV) ? div_count_ff + 1'b1 : '0;
      if (cmd.out_load)   out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else                out_valid_in = out_valid_ff;
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         channel_ff   <= CH_SUPPLY;
         div_count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         channel_ff   <= channel_in;
         div_count_ff <= div_count_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[hdl/stc_dp.sv]
// ----------------------------------------------------------------------------
// Supply and temperature conversion datapath
// Calibration registers, restoring divider, temperature multiply and the
// output word register.
// ----------------------------------------------------------------------------
module stc_dp
   import stc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_wr_data,
   input  logic [ADC_SUM_W-1:0]     adc_sum,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic                     channel,
   output logic [SUPPLY_W-1:0]      supply_centivolts,
   output logic signed [TEMP_W-1:0] temp_decidegrees,
   output logic                     zero_reading
);

   logic signed [CSR_DAT_W-1:0] offset_ff;
   logic [CSR_DAT_W-1:0]        gain_ff;
   logic [AVG_W-1:0]            avg_ff;
   logic [AVG_W-1:0]            rem_ff, rem_in;
   logic [SUPPLY_W-1:0]         quot_ff, quot_in;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [TEMP_W-1:0]    temp_ff;

   logic                        ch_out_ff;
   logic [SUPPLY_W-1:0]         supply_out_ff;
   logic signed [TEMP_W-1:0]    temp_out_ff;
   logic                        zero_out_ff;

   logic [AVG_W:0]              trial;
   logic [AVG_W:0]              trial_diff;
   logic                        fits;

   logic signed [PROD_W-1:0]    diff_ext;
   logic signed [PROD_W-1:0]    gain_ext;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [PROD_W-1:0]    biased;
   logic signed [PROD_W-TEMP_SHIFT-1:0] scaled;
   logic signed [TEMP_W:0]      times5;

   logic [SUPPLY_W-1:0]         supply_val;
   logic                        avg_zero;

   // One restoring division step per cycle, quotient bits shift in at the bottom.
   assign trial      = {rem_ff, quot_ff[SUPPLY_W-1]};
   assign fits       = (trial >= {1'b0, avg_ff});
   assign trial_diff = trial - {1'b0, avg_ff};
   assign rem_in     = fits ? trial_diff[AVG_W-1:0] : trial[AVG_W-1:0];
   assign quot_in    = {quot_ff[SUPPLY_W-2:0], fits};

   assign diff_ext = $signed({{(PROD_W-AVG_W){1'b0}}, avg_ff})
                   - $signed({{(PROD_W-CSR_DAT_W){offset_ff[CSR_DAT_W-1]}}, offset_ff});
   assign gain_ext = $signed({{(PROD_W-CSR_DAT_W){1'b0}}, gain_ff});
   assign prod_in  = diff_ext * gain_ext;

   // Floor shift by taking the upper bits, then times five as shift and add.
   assign biased = prod_ff - KELVIN_BIAS;
   assign scaled = biased[PROD_W-1:TEMP_SHIFT];
   assign times5 = $signed({scaled[TEMP_W-2:0], 2'b00})
                 + $signed({{(TEMP_W+1-(PROD_W-TEMP_SHIFT)){scaled[PROD_W-TEMP_SHIFT-1]}},
                            scaled});

   assign avg_zero        = (avg_ff == '0);
   assign status.avg_zero = avg_zero;

   always_comb begin
      if (avg_zero || quot_ff[SUPPLY_W-1]) supply_val = SUPPLY_SATURATED;
      else                                 supply_val = {quot_ff[SUPPLY_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         gain_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TEMP_OFFSET: offset_ff <= $signed(csr_wr_data);
            CSR_TEMP_GAIN:   gain_ff   <= csr_wr_data;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         avg_ff  <= adc_sum[ADC_SUM_W-1:AVG_SHIFT];
         rem_ff  <= '0;
         quot_ff <= SUPPLY_NUMERATOR;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
      if (cmd.mul_step)  prod_ff <= prod_in;
      if (cmd.temp_step) temp_ff <= times5[TEMP_W-1:0];
      if (cmd.out_load) begin
         ch_out_ff <= cmd.channel;
         if (cmd.channel == CH_TEMP) begin
            supply_out_ff <= '0;
            temp_out_ff   <= temp_ff;
            zero_out_ff   <= 1'b0;
         end else begin
            supply_out_ff <= supply_val;
            temp_out_ff   <= '0;
            zero_out_ff   <= avg_zero;
         end
      end
   end

   assign channel           = ch_out_ff;
   assign supply_centivolts = supply_out_ff;
   assign temp_decidegrees  = temp_out_ff;
   assign zero_reading      = zero_out_ff;

endmodule

[hdl/supply_and_temperature_conversion_core.sv]
// ----------------------------------------------------------------------------
// Supply and temperature conversion core
// Turns accumulated converter sums into supply centivolts and temperature
// in tenths of a degree, alternating between the two channels.
// ----------------------------------------------------------------------------
// Usage: each request word carries the sum of 64 ten-bit samples. Words
// alternate between the internal reference channel and the temperature
// sensor, starting with the reference channel after reset. Each request word
// yields exactly one response word tagged with its channel.
// The reference channel runs a restoring divider, one quotient bit per cycle
// over sixteen divide steps, after an accept and a set-up step and before the
// response register write; a zero average skips the divider. The temperature
// channel uses one registered multiply and one scale step. Response data
// appears the cycle after the write.
// The response register parts the two sides: the next request is accepted
// while a finished response still waits. If the receiver stalls, the next
// word finishes and then waits in its write step until the register is free.
// Reset is synchronous and clears the channel selector, the calibration
// registers and all handshake state; the first word goes to the supply path.
// The user writes the calibration registers through the csr port only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module supply_and_temperature_conversion_core
   import stc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   stc_req_if.sink              req_ch,
   stc_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   // The controller owns the handshake and sequencing.
   stc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the calibration, the arithmetic and the response word.
   stc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .adc_sum           (req_ch.adc_sum),
      .cmd               (cmd),
      .status            (status),
      .channel           (rsp_ch.channel),
      .supply_centivolts (rsp_ch.supply_centivolts),
      .temp_decidegrees  (rsp_ch.temp_decidegrees),
      .zero_reading      (rsp_ch.zero_reading)
   );

   // Only one word is in flight, so intake closes right after an accept.
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while a word is in flight");

   // The datapath is driven by at most one step command in any cycle.
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_step, cmd.mul_step, cmd.temp_step, cmd.out_load}))
      else $error("more than one datapath step commanded");

   // Writing the response register always presents a valid response.
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_ch.valid)
      else $error("response written but not presented");

   // Fields of the other channel read as zero.
   a_supply_fields: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && (cmd.channel == CH_SUPPLY) |=>
         (rsp_ch.channel == CH_SUPPLY) && (rsp_ch.temp_decidegrees == '0))
      else $error("supply response carries a temperature");

   a_temp_fields: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && (cmd.channel == CH_TEMP) |=>
         (rsp_ch.channel == CH_TEMP) && (rsp_ch.supply_centivolts == '0)
         && !rsp_ch.zero_reading)
      else $error("temperature response carries supply fields");

endmodule

[tb/supply_and_temperature_conversion_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supply and temperature conversion core testbench
// Drives accumulated converter sums through the request channel and checks
// every response word against a cycle-free model of the conversion. The
// model tracks the alternating channel and the calibration registers.
// Directed corner sums come first, then random sums under several
// calibration settings. The sender works in bursts with random gaps, and
// the receiver throttles the response channel on its own random pattern.
// ----------------------------------------------------------------------------
module supply_and_temperature_conversion_core_test
   import stc_pkg::*;
;

   // Scale from the shifted temperature term to tenths of a degree.
   localparam int TEMP_SCALE    = 5;
   // Cycles to let pass once every expected word is back, a bit more than
   // the slowest conversion, a full divide.
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_WORDS   = 125;
   localparam int RANDOM_PHASES = 12;
   localparam int MAX_REPORTS   = 10;
   // Slowest correct run is about 1500 words, each with a full divide, the
   // longest sender gap and the longest receiver stall, a little over 1 ms;
   // the limit allows many times that.
   localparam longint LIMIT_NS  = 64'd10_000_000;

   // One response word as the block should present it.
   typedef struct packed {
      logic                     channel;
      logic [SUPPLY_W-1:0]      supply_centivolts;
      logic signed [TEMP_W-1:0] temp_decidegrees;
      logic                     zero_reading;
   } reading_type;

   // The scoreboard keeps its own copy of the channel selector and the
   // calibration registers, turns each accepted sum into the reading it
   // must produce, and matches response words in order.
   class reading_scoreboard;
      reading_type                 expected_readings[$];
      logic                        next_channel = CH_SUPPLY;
      logic signed [CSR_DAT_W-1:0] temp_offset  = '0;
      logic [CSR_DAT_W-1:0]        temp_gain    = '0;
      int                          mismatches   = 0;

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         if (idx == CSR_TEMP_OFFSET) begin
            temp_offset = data;
         end else if (idx == CSR_TEMP_GAIN) begin
            temp_gain = data;
         end
      endfunction

      // Works out the reading for one sum on the current channel and flips
      // the channel, as the block does after every word.
      function reading_type convert_sum(logic [ADC_SUM_W-1:0] sum);
         reading_type      r;
         logic [AVG_W-1:0] avg;
         int               quotient;
         int               term;
         int               scaled;
         r   = '0;
         avg = sum[ADC_SUM_W-1:AVG_SHIFT];
         if (next_channel == CH_SUPPLY) begin
            r.channel = CH_SUPPLY;
            if (avg == '0) begin
               // No division on a zero average: flag it and report full scale.
               r.zero_reading      = 1'b1;
               r.supply_centivolts = SUPPLY_SATURATED;
            end else begin
               quotient = (int'(SUPPLY_NUMERATOR) / int'(avg)) * 2;
               // Only an average of one overflows 16 bits.
               if (quotient > int'(SUPPLY_SATURATED)) begin
                  r.supply_centivolts = SUPPLY_SATURATED;
               end else begin
                  r.supply_centivolts = quotient[SUPPLY_W-1:0];
               end
            end
            next_channel = CH_TEMP;
         end else begin
            r.channel = CH_TEMP;
            term   = (int'(avg) - int'(temp_offset)) * int'(temp_gain) - int'(KELVIN_BIAS);
            // Arithmetic shift of a signed int rounds toward minus infinity.
            scaled = (term >>> TEMP_SHIFT) * TEMP_SCALE;
            r.temp_decidegrees = scaled[TEMP_W-1:0];
            next_channel = CH_SUPPLY;
         end
         return r;
      endfunction

      function void note_sum(logic [ADC_SUM_W-1:0] sum);
         expected_readings.push_back(convert_sum(sum));
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: response word with nothing expected:", $realtime);
               $display("%0t:   ch=%0d supply=%0d temp=%0d zero=%0d",
                        $realtime, got.channel, got.supply_centivolts,
                        got.temp_decidegrees, got.zero_reading);
            end
         end else begin
            want = expected_readings.pop_front();
            if (got.channel !== want.channel ||
                got.supply_centivolts !== want.supply_centivolts ||
                got.temp_decidegrees !== want.temp_decidegrees ||
                got.zero_reading !== want.zero_reading) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: mismatch: expected ch=%0d supply=%0d temp=%0d zero=%0d",
                           $realtime, want.channel, want.supply_centivolts,
                           want.temp_decidegrees, want.zero_reading);
                  $display("%0t:           actual   ch=%0d supply=%0d temp=%0d zero=%0d",
                           $realtime, got.channel, got.supply_centivolts,
                           got.temp_decidegrees, got.zero_reading);
               end
            end
         end
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

   // Receiver behavior: free running, coin-flip throttling, or a hard stall.
   typedef enum logic [1:0] {
      RX_FREE,
      RX_CHOPPY,
      RX_BLOCKED
   } rx_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wr_data;

   stc_req_if req_if ();
   stc_rsp_if rsp_if ();

   reading_scoreboard readings = new();

   rx_mode_type rx_mode = RX_FREE;
   int          rx_left = 0;

   supply_and_temperature_conversion_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run in case the block stops answering.
   initial begin
      #(LIMIT_NS);
      $display("** supply_and_temperature_conversion_core: FAILED **");
      $finish;
   end

   // The receiver picks a mode, holds it for a random stretch, then picks
   // again. Hard stalls make the next word wait in its write step while the
   // request side keeps going.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         if (rx_mode == RX_BLOCKED) begin
            rx_left = $urandom_range(1, 30);
         end else begin
            rx_left = $urandom_range(10, 150);
         end
      end
      rx_left = rx_left - 1;
      case (rx_mode)
         RX_FREE: begin
            rsp_if.ready <= 1'b1;
         end
         RX_CHOPPY: begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_if.ready <= 1'b0;
         end
      endcase
   end

   // Every accepted response word is checked against the oldest expectation.
   // Sampling at the edge sees the values the block saw.
   always @(posedge clock) begin
      reading_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.channel           = rsp_if.channel;
         got.supply_centivolts = rsp_if.supply_centivolts;
         got.temp_decidegrees  = rsp_if.temp_decidegrees;
         got.zero_reading      = rsp_if.zero_reading;
         readings.check_reading(got);
      end
   end

   // Offers one sum and holds it until the block takes the word. The
   // expectation is recorded here, in step with acceptance.
   task automatic send_word(input logic [ADC_SUM_W-1:0] sum);
      req_if.valid   <= 1'b1;
      req_if.adc_sum <= sum;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      readings.note_sum(sum);
   endtask

   // Waits until every expected word is back and the block has settled.
   task automatic wait_quiet();
      while (readings.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      readings.set_register(idx, data);
   endtask

   // Calibration only changes while the block is idle.
   task automatic apply_settings(input logic [CSR_DAT_W-1:0] offset,
                                 input logic [CSR_DAT_W-1:0] gain);
      wait_quiet();
      write_register(CSR_TEMP_OFFSET, offset);
      write_register(CSR_TEMP_GAIN, gain);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly uniform sums, with extra weight near both ends so that zero and
   // one averages and the top of the range come up often.
   function automatic logic [ADC_SUM_W-1:0] random_sum();
      case ($urandom_range(0, 7))
         0: return ADC_SUM_W'($urandom_range(0, 127));
         1: return ADC_SUM_W'($urandom_range(65408, 65535));
         default: return ADC_SUM_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [CSR_DAT_W-1:0] random_offset();
      case ($urandom_range(0, 5))
         0: return 8'h80;
         1: return 8'h7F;
         2: return 8'h00;
         default: return CSR_DAT_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CSR_DAT_W-1:0] random_gain();
      case ($urandom_range(0, 4))
         0: return 8'h00;
         1: return 8'hFF;
         default: return CSR_DAT_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Sends a run of random sums in bursts. Random gaps land on every step of
   // the divide; some bursts follow each other with no gap at all.
   task automatic run_random(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && sent < count) begin
            send_word(random_sum());
            sent++;
            burst--;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clock);
         end
      end
      req_if.valid <= 1'b0;
   endtask

   // Corner sums: zero average at both ends of its range, average of one
   // (the only supply overflow), average of two, full scale, and
   // alternating bit patterns. Each is sent twice so that it lands on the
   // supply channel and then on the temperature channel.
   logic [ADC_SUM_W-1:0] corner_sums[9] = '{16'd0, 16'd63, 16'd64, 16'd127, 16'd128,
                                            16'hFFFF, 16'hFFC0, 16'h5555, 16'hAAAA};
   // Fixed settings for the first random phases: zero gain at both offset
   // extremes, then the reset values.
   logic [CSR_DAT_W-1:0] fixed_offsets[3] = '{8'h7F, 8'h80, 8'h00};
   logic [CSR_DAT_W-1:0] fixed_gains[3]   = '{8'h00, 8'h00, 8'h00};

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.adc_sum = '0;
      rsp_if.ready   = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Lowest offset with full gain gives the hottest reading the fields
      // allow at full-scale sums.
      apply_settings(8'h80, 8'hFF);
      foreach (corner_sums[i]) begin
         send_word(corner_sums[i]);
         send_word(corner_sums[i]);
      end
      req_if.valid <= 1'b0;

      // Highest offset with full gain gives the coldest reading at a zero sum.
      apply_settings(8'h7F, 8'hFF);
      send_word(16'd0);
      send_word(16'd0);
      send_word(16'hFFFF);
      send_word(16'hFFFF);
      req_if.valid <= 1'b0;

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 3) begin
            apply_settings(fixed_offsets[phase], fixed_gains[phase]);
         end else begin
            apply_settings(random_offset(), random_gain());
         end
         run_random(PHASE_WORDS);
      end

      wait_quiet();
      if (readings.mismatches == 0 && readings.pending() == 0) begin
         $display("** supply_and_temperature_conversion_core: PASSED **");
      end else begin
         $display("** supply_and_temperature_conversion_core: FAILED **");
      end
      $finish;
   end

endmodule
